// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define LRC_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define LRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`define LRC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define LRC_ASSERT_ALWAYS(lbl, expr)
`define LRC_ASSERT_NEXT(lbl, ante, cons)
`define LRC_ASSERT_SAME(lbl, ante, cons)
`endif

`endif

// ===== hw/rtl/lrc_pkg.sv =====
// Types and constants of the literal renaming checker.
package lrc_pkg;

    localparam int NUM_VARS = 4096;
    localparam int VAR_W    = $clog2(NUM_VARS);
    localparam int LIT_W    = 13;

    typedef logic signed [LIT_W-1:0] lit_t;
    typedef logic [1:0]              verdict_t;

    localparam verdict_t VERDICT_RUN    = 2'd0;
    localparam verdict_t VERDICT_ACCEPT = 2'd1;
    localparam verdict_t VERDICT_REJECT = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [VAR_W-1:0] target;
    } map_entry_t;

    function automatic logic [LIT_W-1:0] lit_mag(input lit_t x);
        logic [LIT_W-1:0] m;
        m = x[LIT_W-1] ? (~x + 1'b1) : x;
        return m;
    endfunction

endpackage

// ===== hw/rtl/literal_renaming_checker_unit.sv =====
// Top level of the literal renaming checker: map memories, sequencer and verdict register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  in      | input     | in_valid/in_stall   | first_literal, second_literal, first_done,
//          |           |                    | second_done
//  out     | output    | out_valid/out_stall | verdict (one transfer per input transfer)
//
// Each input transfer is handled as a synchronous read of both maps on acceptance, then a
// judge step (ST_LOOKUP) that writes back and loads the output register; in_stall stays high until it ends.
// After reset a clearing pass sweeps all NUM_VARS (4096) entries of both maps, one
// entry a cycle, with in_stall high.
// A result held by out_stall keeps the block in its judge state; the verdict is sticky.
module literal_renaming_checker_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  lrc_pkg::lit_t        first_literal,
    input  lrc_pkg::lit_t        second_literal,
    input  logic                 first_done,
    input  logic                 second_done,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lrc_pkg::verdict_t    verdict
);
    import lrc_pkg::*;

    `include "assert_macros.svh"

    map_entry_t       fmap_mem [NUM_VARS];
    logic             used_mem [NUM_VARS];

    state_t           state_reg, state_next;
    logic [VAR_W-1:0] clr_cnt_reg, clr_cnt_next;
    verdict_t         status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    verdict_t         verdict_reg;

    lit_t             a_reg, d_reg;
    logic             a_done_reg, d_done_reg;
    map_entry_t       fmap_q_reg;
    logic             used_q_reg;

    logic [LIT_W-1:0] am_in, dm_in, am, dm;
    logic             accept;
    logic             step_done;
    verdict_t         judge;
    logic             new_map;
    logic             mem_we;
    logic [VAR_W-1:0] fmap_waddr, used_waddr;
    map_entry_t       fmap_wdata;
    logic             used_wdata;

    assign am_in = lit_mag(first_literal);
    assign dm_in = lit_mag(second_literal);
    assign am    = lit_mag(a_reg);
    assign dm    = lit_mag(d_reg);

    assign accept    = in_valid && !in_stall;
    assign step_done = (state_reg == ST_LOOKUP) && (!out_valid_reg || !out_stall);

    // pair judgement on latched literals and map read data
    always_comb
    begin
        judge   = VERDICT_RUN;
        new_map = 1'b0;
        if (d_done_reg)
        begin
            judge = a_done_reg ? VERDICT_ACCEPT : VERDICT_REJECT;
        end
        else if (a_done_reg)
        begin
            judge = VERDICT_REJECT;
        end
        else if (d_reg == '0)
        begin
            judge = (a_reg != '0) ? VERDICT_REJECT : VERDICT_RUN;
        end
        else if ((a_reg[LIT_W-1] && !d_reg[LIT_W-1]) ||
                 (!a_reg[LIT_W-1] && (a_reg != '0) && d_reg[LIT_W-1]))
        begin
            judge = VERDICT_REJECT;
        end
        else if ((am >= LIT_W'(NUM_VARS)) || (dm >= LIT_W'(NUM_VARS)))
        begin
            judge = VERDICT_REJECT;
        end
        else if (fmap_q_reg.valid)
        begin
            judge = (fmap_q_reg.target != dm[VAR_W-1:0]) ? VERDICT_REJECT : VERDICT_RUN;
        end
        else if (used_q_reg)
        begin
            judge = VERDICT_REJECT;
        end
        else
        begin
            new_map = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        mem_we         = 1'b0;
        fmap_waddr     = am[VAR_W-1:0];
        used_waddr     = dm[VAR_W-1:0];
        fmap_wdata     = '{valid: 1'b1, target: dm[VAR_W-1:0]};
        used_wdata     = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                fmap_waddr   = clr_cnt_reg;
                used_waddr   = clr_cnt_reg;
                fmap_wdata   = '0;
                used_wdata   = 1'b0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == VAR_W'(NUM_VARS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (step_done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (status_reg == VERDICT_RUN)
                    begin
                        status_next = judge;
                        mem_we      = new_map;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            status_reg    <= VERDICT_RUN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg      <= first_literal;
            d_reg      <= second_literal;
            a_done_reg <= first_done;
            d_done_reg <= second_done;
        end
        if (step_done)
        begin
            verdict_reg <= status_next;
        end
    end

    // map memories: read on transfer, written on clear or new mapping
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fmap_mem[fmap_waddr] <= fmap_wdata;
        end
        if (accept)
        begin
            fmap_q_reg <= fmap_mem[am_in[VAR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
        if (accept)
        begin
            used_q_reg <= used_mem[dm_in[VAR_W-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    `LRC_ASSERT_NEXT(a_sticky_verdict, status_reg != VERDICT_RUN, $stable(status_reg))
    `LRC_ASSERT_SAME(a_out_from_lookup, $rose(out_valid_reg), $past(state_reg == ST_LOOKUP))
    `LRC_ASSERT_SAME(a_out_matches_status, out_valid_reg, verdict_reg == status_reg)
    `LRC_ASSERT_ALWAYS(a_no_write_idle, !(mem_we && state_reg == ST_IDLE))

endmodule

// ===== dv/literal_renaming_checker_unit_tb.sv =====
// Testbench for the literal renaming checker: renaming streams, one final verdict, sticky tail.
module literal_renaming_checker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrc_pkg::*;

    localparam int ITEM_COUNT   = 1100;
    localparam int STICKY_COUNT = 40;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_CYCLES = 6;

    typedef enum int {
        BRK_ACCEPT,
        BRK_SECOND_DONE,
        BRK_FIRST_DONE,
        BRK_END_MISMATCH,
        BRK_POLARITY,
        BRK_RANGE,
        BRK_REMAP,
        BRK_REUSE
    } break_kind_t;

    class verdict_scoreboard;
        bit [VAR_W-1:0] fwd_target [NUM_VARS];
        bit             fwd_valid  [NUM_VARS];
        bit             tgt_used   [NUM_VARS];
        verdict_t       status;
        verdict_t       pending [$];
        int             mismatch_count;

        function new();
            status         = VERDICT_RUN;
            mismatch_count = 0;
        endfunction

        function verdict_t judge_pair(lit_t a, lit_t d, logic a_done, logic d_done);
            int sa;
            int sd;
            int ma;
            int md;
            sa = int'(a);
            sd = int'(d);
            if (d_done)
                return a_done ? VERDICT_ACCEPT : VERDICT_REJECT;
            if (a_done)
                return VERDICT_REJECT;
            if (sd == 0)
                return (sa != 0) ? VERDICT_REJECT : VERDICT_RUN;
            if ((sa < 0 && sd > 0) || (sa > 0 && sd < 0))
                return VERDICT_REJECT;
            ma = (sa < 0) ? -sa : sa;
            md = (sd < 0) ? -sd : sd;
            if (ma >= NUM_VARS || md >= NUM_VARS)
                return VERDICT_REJECT;
            if (fwd_valid[ma])
                return (int'(fwd_target[ma]) != md) ? VERDICT_REJECT : VERDICT_RUN;
            if (tgt_used[md])
                return VERDICT_REJECT;
            fwd_valid[ma]  = 1'b1;
            fwd_target[ma] = md[VAR_W-1:0];
            tgt_used[md]   = 1'b1;
            return VERDICT_RUN;
        endfunction

        function void note_transfer(lit_t a, lit_t d, logic a_done, logic d_done);
            if (status == VERDICT_RUN)
                status = judge_pair(a, d, a_done, d_done);
            pending.push_back(status);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (pending.size() == 0)
            begin
                $error("verdict: no transfer outstanding, expected none, actual %0d", got);
                mismatch_count++;
            end
            else
            begin
                want = pending.pop_front();
                if (got !== want)
                begin
                    $error("verdict: expected %0d, actual %0d", want, got);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    lit_t     first_literal;
    lit_t     second_literal;
    logic     first_done;
    logic     second_done;
    logic     out_valid;
    logic     out_stall;
    verdict_t verdict;

    verdict_scoreboard sb;
    int idle_pct  = 18;
    int stall_pct = 77;
    int cycle_count;

    // stimulus-side view of the renaming, kept consistent by construction
    int gen_target [NUM_VARS];
    bit gen_used   [NUM_VARS];
    int gen_vars [$];

    literal_renaming_checker_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_literal  (first_literal),
        .second_literal (second_literal),
        .first_done     (first_done),
        .second_done    (second_done),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_transfer(first_literal, second_literal, first_done, second_done);
            if (out_valid && !out_stall)
                sb.check_verdict(verdict);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_pair(input lit_t a, input lit_t d, input logic a_done,
                             input logic d_done);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        first_literal  <= a;
        second_literal <= d;
        first_done     <= a_done;
        second_done    <= d_done;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic void record_pair(int a, int d);
        int ma;
        int md;
        ma = (a < 0) ? -a : a;
        md = (d < 0) ? -d : d;
        if (d != 0 && gen_target[ma] < 0)
        begin
            gen_target[ma] = md;
            gen_used[md]   = 1'b1;
            gen_vars.push_back(ma);
        end
    endfunction

    function automatic int fresh_var();
        int v;
        do
            v = $urandom_range(1, NUM_VARS - 1);
        while (gen_target[v] >= 0);
        return v;
    endfunction

    function automatic int fresh_target();
        int t;
        do
            t = $urandom_range(1, NUM_VARS - 1);
        while (gen_used[t]);
        return t;
    endfunction

    task automatic send_consistent();
        int r;
        int v;
        int t;
        bit neg;
        r   = $urandom_range(99);
        neg = 1'($urandom_range(1));
        if (r < 20)
        begin
            v = 0;
            t = 0;
        end
        else if (r < 55)
        begin
            v = gen_vars[$urandom_range(gen_vars.size() - 1)];
            t = gen_target[v];
        end
        else
        begin
            v = fresh_var();
            t = fresh_target();
        end
        if (neg)
        begin
            v = -v;
            t = -t;
        end
        record_pair(v, t);
        send_pair(lit_t'(v), lit_t'(t), 1'b0, 1'b0);
    endtask

    task automatic send_break();
        break_kind_t kind;
        int v;
        int t;
        kind = break_kind_t'($urandom_range(BRK_REUSE));
        v = $urandom_range(1, NUM_VARS - 1);
        t = $urandom_range(1, NUM_VARS - 1);
        case (kind)
            BRK_ACCEPT:
                send_pair(lit_t'($urandom), lit_t'($urandom), 1'b1, 1'b1);
            BRK_SECOND_DONE:
                send_pair(lit_t'($urandom), lit_t'($urandom), 1'b0, 1'b1);
            BRK_FIRST_DONE:
                send_pair(lit_t'($urandom), lit_t'($urandom), 1'b1, 1'b0);
            BRK_END_MISMATCH:
                send_pair(lit_t'($urandom_range(1) ? -v : v), lit_t'(0), 1'b0, 1'b0);
            BRK_POLARITY:
                if ($urandom_range(1))
                    send_pair(lit_t'(v), lit_t'(-t), 1'b0, 1'b0);
                else
                    send_pair(lit_t'(-v), lit_t'(t), 1'b0, 1'b0);
            BRK_RANGE:
                if ($urandom_range(1))
                    send_pair(lit_t'(-NUM_VARS), lit_t'(-$urandom_range(1, NUM_VARS)),
                              1'b0, 1'b0);
                else
                    send_pair(lit_t'(-v), lit_t'(-NUM_VARS), 1'b0, 1'b0);
            BRK_REMAP:
            begin
                v = gen_vars[$urandom_range(gen_vars.size() - 1)];
                do
                    t = $urandom_range(1, NUM_VARS - 1);
                while (t == gen_target[v]);
                send_pair(lit_t'(v), lit_t'(t), 1'b0, 1'b0);
            end
            default:
            begin
                v = fresh_var();
                t = gen_target[gen_vars[$urandom_range(gen_vars.size() - 1)]];
                send_pair(lit_t'(-v), lit_t'(-t), 1'b0, 1'b0);
            end
        endcase
    endtask

    initial
    begin
        int dir_a [14];
        int dir_d [14];
        int idx;
        dir_a = '{0, 1, -4095, 0, 0, -1, 4095, 0, 2048, -2048, 1365, -1365, 2730, 0};
        dir_d = '{0, 4095, -1, 7, -7, -4095, 1, 0, 2048, -2048, 2730, -2730, 1365, 0};
        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        first_literal  = '0;
        second_literal = '0;
        first_done     = 1'b0;
        second_done    = 1'b0;
        out_stall      = 1'b0;
        foreach (gen_target[i])
            gen_target[i] = -1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, clause ends, variable zero against a nonzero literal
        foreach (dir_a[i])
        begin
            record_pair(dir_a[i], dir_d[i]);
            send_pair(lit_t'(dir_a[i]), lit_t'(dir_d[i]), 1'b0, 1'b0);
        end

        for (idx = $size(dir_a); idx < ITEM_COUNT; idx++)
        begin
            if (idx == ITEM_COUNT / 3)
            begin
                idle_pct  = 77;
                stall_pct = 18;
            end
            else if (idx == 2 * ITEM_COUNT / 3)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            send_consistent();
        end
        send_break();

        // verdict is sticky: arbitrary patterns from here on
        repeat (STICKY_COUNT)
            send_pair(lit_t'($urandom), lit_t'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lrc_pkg.sv
hw/rtl/literal_renaming_checker_unit.sv
dv/literal_renaming_checker_unit_tb.sv
